@@ rtl/core/slcg_pkg.sv @@
// Shared types and constants for the shuffled LCG random generator.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package slcg_pkg;

   // Value and field widths
   localparam int VAL_W  = 20;
   localparam int SEED_W = 21;
   localparam int MUL_W  = 11;
   localparam int PROD_W = 30;
   localparam int QUO_W  = 11;

   // Generator step: x' = (LCG_MUL * x + LCG_INC) mod LCG_MOD
   localparam logic [VAL_W-1:0] LCG_MOD = 20'd714025;
   localparam logic [MUL_W-1:0] LCG_MUL = 11'd1366;
   localparam logic [VAL_W-1:0] LCG_INC = 20'd150889;

   // floor(v / LCG_MOD) ~= (v * RECIP) >> RECIP_SHIFT, high by at most one for v < 2**30
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 11;
   localparam logic [RECIP_W-1:0] RECIP = 11'd1504;

   localparam int DEFAULT_TABLE_DEPTH = 97;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic             reseed;
      logic [VAL_W-1:0] seed_state;
   } slcg_cmd_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quo;
      logic [VAL_W-1:0] rem;
   } slcg_dm_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL_ISSUE,
      ST_FILL_WAIT,
      ST_SLOT_ISSUE,
      ST_SLOT_WAIT,
      ST_GEN_ISSUE,
      ST_GEN_WAIT,
      ST_PUSH
   } slcg_state_type;

endpackage

`default_nettype wire

@@ rtl/core/slcg_divmod.sv @@
// Three-stage multiply-add and divide by the generator modulus.
// Computes v = a*b + c, then quotient and remainder of v / 714025. Uses slcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slcg_divmod
   import slcg_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             issue,
   input  wire logic [VAL_W-1:0] op_a,
   input  wire logic [MUL_W-1:0] op_b,
   input  wire logic [VAL_W-1:0] op_c,
   output slcg_dm_type           result
);

   logic [2:0]               vld_ff;
   logic [VAL_W+MUL_W-1:0]   prod;
   logic [PROD_W-1:0]        v1_in, v1_ff, v2_ff;
   logic [PROD_W+RECIP_W-1:0] qprod;
   logic [QUO_W-1:0]         q_in, q_ff, q3_ff;
   logic [QUO_W+VAL_W-1:0]   mprod;
   logic [PROD_W+1:0]        diff;
   logic [VAL_W:0]           t_in, t_ff;
   logic                     neg;

   always_comb begin
      prod  = {{MUL_W{1'b0}}, op_a} * {{VAL_W{1'b0}}, op_b};
      v1_in = PROD_W'(prod + (VAL_W+MUL_W)'(op_c));
      qprod = {{RECIP_W{1'b0}}, v1_ff} * {{PROD_W{1'b0}}, RECIP};
      q_in  = qprod[RECIP_SHIFT +: QUO_W];
      mprod = {{VAL_W{1'b0}}, q_ff} * {{QUO_W{1'b0}}, LCG_MOD};
      diff  = {2'b00, v2_ff} - {1'b0, mprod};
      // estimate is exact or one high, so the difference lies in (-MOD, MOD)
      t_in  = diff[VAL_W:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      v1_ff <= v1_in;
      v2_ff <= v1_ff;
      q_ff  <= q_in;
      q3_ff <= q_ff;
      t_ff  <= t_in;
   end

   always_comb begin
      neg         = t_ff[VAL_W];
      result.done = vld_ff[2];
      result.rem  = neg ? VAL_W'(t_ff + {1'b0, LCG_MOD}) : t_ff[VAL_W-1:0];
      result.quo  = neg ? QUO_W'(q3_ff - 1'b1) : q3_ff;
   end

   a_rem_in_range: assert property (@(posedge clock) disable iff (reset)
      result.done |-> (result.rem < LCG_MOD))
      else $error("divmod remainder not below modulus");

endmodule

`default_nettype wire

@@ rtl/core/slcg_queue.sv @@
// Short command queue between the request front and the draw engine.
// Holds slcg_cmd_type entries; uses slcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slcg_queue
   import slcg_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire slcg_cmd_type push_cmd,
   output logic        full,
   input  wire logic   pop,
   output logic        head_valid,
   output slcg_cmd_type head_cmd
);

   slcg_cmd_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   always_comb begin
      full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
      head_valid = (count_ff != '0);
      head_cmd   = entry_ff[rd_ptr_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |=> (count_ff != '0))
      else $error("queue lost entries while full");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == QCNT_W'($past(count_ff) + 1'b1)))
      else $error("queue count did not advance on push");

endmodule

`default_nettype wire

@@ rtl/core/slcg_front.sv @@
// Request front: takes request beats, decides reseed versus draw, maps the seed.
// Feeds slcg_queue; uses slcg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module slcg_front
   import slcg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_opcode,
   input  wire logic signed [SEED_W-1:0] req_seed,
   input  wire logic              q_full,
   output logic                   q_push,
   output slcg_cmd_type           q_cmd
);

   logic              seen_ff;
   logic [SEED_W:0]   diff;
   logic [SEED_W:0]   mag;
   logic [SEED_W-1:0] mag_lo;

   always_comb begin
      req_stall = q_full;
      q_push    = req_valid;
      // |(150889 - seed) rem 714025|: magnitude, then one conditional subtract
      diff   = {2'b00, LCG_INC} - {req_seed[SEED_W-1], req_seed};
      mag    = diff[SEED_W] ? (SEED_W+1)'(~diff + 1'b1) : diff;
      mag_lo = mag[SEED_W-1:0];
      q_cmd.seed_state = (mag_lo >= {1'b0, LCG_MOD}) ?
                         VAL_W'(mag_lo - {1'b0, LCG_MOD}) : mag_lo[VAL_W-1:0];
      // first beat after reset always seeds the table
      q_cmd.reseed = req_opcode || !seen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         seen_ff <= 1'b1;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/slcg_back.sv @@
// Draw engine: fills the shuffle table, draws and refills one slot per command.
// Holds the shuffle memory and result register; uses slcg_pkg and slcg_divmod.
`timescale 1ns / 1ps
`default_nettype none

module slcg_back
   import slcg_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire slcg_cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [VAL_W-1:0] rsp_random_value
);

   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);
   localparam logic [QUO_W-1:0] DEPTH_Q = QUO_W'(TABLE_DEPTH);

   slcg_state_type     state_ff, state_in;
   slcg_dm_type        dm;
   logic               dm_issue, sel_slot;
   logic [VAL_W-1:0]   op_a, op_c;
   logic [MUL_W-1:0]   op_b;
   logic               mem_we, rsp_load;
   logic [SLOT_W-1:0]  wr_addr;
   logic [VAL_W-1:0]   mem [TABLE_DEPTH];
   logic [VAL_W-1:0]   rd_ff;
   logic [VAL_W-1:0]   gen_ff, gen_in, last_ff, last_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic               rsp_valid_ff;
   logic [VAL_W-1:0]   rsp_value_ff;

   slcg_divmod u_divmod (
      .clock  (clock),
      .reset  (reset),
      .issue  (dm_issue),
      .op_a   (op_a),
      .op_b   (op_b),
      .op_c   (op_c),
      .result (dm)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = q_cmd.reseed ? ST_FILL_ISSUE : ST_SLOT_ISSUE;
            end
         end
         ST_FILL_ISSUE: state_in = ST_FILL_WAIT;
         ST_FILL_WAIT: begin
            if (dm.done) begin
               state_in = (cnt_ff == CNT_END) ? ST_SLOT_ISSUE : ST_FILL_ISSUE;
            end
         end
         ST_SLOT_ISSUE: state_in = ST_SLOT_WAIT;
         ST_SLOT_WAIT: begin
            if (dm.done) begin
               state_in = ST_GEN_ISSUE;
            end
         end
         ST_GEN_ISSUE: state_in = ST_GEN_WAIT;
         ST_GEN_WAIT: begin
            if (dm.done) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop    = (state_ff == ST_IDLE) && q_valid;
      dm_issue = (state_ff == ST_FILL_ISSUE) || (state_ff == ST_SLOT_ISSUE) ||
                 (state_ff == ST_GEN_ISSUE);
      sel_slot = (state_ff == ST_SLOT_ISSUE);
      mem_we   = ((state_ff == ST_FILL_WAIT) && dm.done && (cnt_ff != CNT_END)) ||
                 ((state_ff == ST_GEN_WAIT) && dm.done);
      wr_addr  = (state_ff == ST_FILL_WAIT) ? cnt_ff[SLOT_W-1:0] : slot_ff;
      rsp_load = (state_ff == ST_PUSH) && (!rsp_valid_ff || !rsp_stall);
   end

   // datapath next values
   always_comb begin
      // slot = floor(depth * last / mod), or one generator step on gen
      op_a = sel_slot ? last_ff : gen_ff;
      op_b = sel_slot ? MUL_W'(TABLE_DEPTH) : LCG_MUL;
      op_c = sel_slot ? '0 : LCG_INC;

      slot_in = (dm.quo >= DEPTH_Q) ? SLOT_W'(TABLE_DEPTH - 1) : dm.quo[SLOT_W-1:0];

      gen_in  = gen_ff;
      last_in = last_ff;
      cnt_in  = cnt_ff;
      if (q_pop && q_cmd.reseed) begin
         gen_in = q_cmd.seed_state;
         cnt_in = '0;
      end
      if ((state_ff == ST_FILL_WAIT) && dm.done) begin
         gen_in = dm.rem;
         if (cnt_ff == CNT_END) begin
            last_in = dm.rem;
         end else begin
            cnt_in = CNT_W'(cnt_ff + 1'b1);
         end
      end
      if ((state_ff == ST_GEN_WAIT) && dm.done) begin
         gen_in  = dm.rem;
         last_in = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gen_ff       <= '0;
         last_ff      <= '0;
      end else begin
         state_ff <= state_in;
         gen_ff   <= gen_in;
         last_ff  <= last_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if ((state_ff == ST_SLOT_WAIT) && dm.done) begin
         slot_ff <= slot_in;
      end
      if (rsp_load) begin
         rsp_value_ff <= last_ff;
      end
   end

   // shuffle table: one write port, registered read of the chosen slot
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= dm.rem;
      end
      rd_ff <= mem[slot_ff];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

   a_divmod_latency: assert property (@(posedge clock) disable iff (reset)
      dm_issue |-> ##3 dm.done)
      else $error("divmod result not back after three cycles");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (32'(wr_addr) < TABLE_DEPTH))
      else $error("shuffle table write outside table");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten before taken");

endmodule

`default_nettype wire

@@ rtl/core/shuffled_lcg_random_generator_unit.sv @@
// Top level of the Bays-Durham shuffled LCG random generator.
// Instantiates slcg_front, slcg_queue and slcg_back; uses slcg_pkg.
//
//   port group   dir   fields                      handshake
//   req_*        in    opcode[0], seed[20:0] s     req_valid / req_stall
//   rsp_*        out   random_value[19:0]          rsp_valid / rsp_stall
//
// A draw in the engine pops the command, makes two passes through the three-stage
// divide-by-714025 unit (slot pick, then the refill value) and pushes the result.
// A reseed first fills the table with TABLE_DEPTH + 1 passes, one generator step per pass.
// Reset is synchronous; the first beat after reset always reseeds the table.
// A two-beat queue keeps req_* open, until it fills, while the engine works or rsp_* is stalled.
`timescale 1ns / 1ps
`default_nettype none

module shuffled_lcg_random_generator_unit
   import slcg_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_opcode,
   input  wire logic signed [SEED_W-1:0] req_seed,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [VAL_W-1:0]              rsp_random_value
);

   logic         q_full, q_push, q_pop, q_valid;
   slcg_cmd_type push_cmd, head_cmd;

   slcg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_seed   (req_seed),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (push_cmd)
   );

   slcg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (head_cmd)
   );

   slcg_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_cmd            (head_cmd),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value)
   );

endmodule

`default_nettype wire

@@ tb/tb_shuffled_lcg_random_generator_unit.sv @@
// Self-checking bench for shuffled_lcg_random_generator_unit: a draw scoreboard
// predicts each value from the shuffle table. Depends on slcg_pkg and the RTL.
`timescale 1ns / 1ps

module tb_shuffled_lcg_random_generator_unit;
   import slcg_pkg::*;

   localparam int DEPTH          = DEFAULT_TABLE_DEPTH;
   localparam logic OP_DRAW      = 1'b0;
   localparam logic OP_RESEED    = 1'b1;
   localparam int RANDOM_ITEMS   = 630;
   localparam int CALM_ITEMS     = 100;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 40;

   // Predicts draws from its own copy of table, generator and last value.
   class draw_scoreboard;
      logic [VAL_W-1:0] slots [DEPTH];
      logic [VAL_W-1:0] gen_state;
      logic [VAL_W-1:0] last_value;
      bit               seeded;
      logic [VAL_W-1:0] pending_draws [$];
      int unsigned      errors;

      function new();
         foreach (slots[k]) slots[k] = '0;
         gen_state  = '0;
         last_value = '0;
         seeded     = 1'b0;
         errors     = 0;
      endfunction

      function logic [VAL_W-1:0] step_lcg(logic [VAL_W-1:0] x);
         longint unsigned xv, modulus, v;
         xv      = x;
         modulus = LCG_MOD;
         v       = (xv % modulus) * LCG_MUL + LCG_INC;
         return VAL_W'(v % modulus);
      endfunction

      function void fill_table(logic signed [SEED_W-1:0] seed);
         longint s, m;
         s = seed;
         // rem truncates toward zero, then magnitude
         m = (longint'(LCG_INC) - s) % longint'(LCG_MOD);
         if (m < 0) m = -m;
         gen_state = VAL_W'(m);
         for (int k = 0; k < DEPTH; k++) begin
            gen_state = step_lcg(gen_state);
            slots[k]  = gen_state;
         end
         gen_state  = step_lcg(gen_state);
         last_value = gen_state;
         seeded     = 1'b1;
      endfunction

      function void note_request(logic opcode, logic signed [SEED_W-1:0] seed);
         longint unsigned pick;
         logic [VAL_W-1:0] drawn;
         if (opcode == OP_RESEED || !seeded) fill_table(seed);
         pick = (longint'(DEPTH) * longint'(last_value)) / longint'(LCG_MOD);
         if (pick >= DEPTH) pick = DEPTH - 1;
         drawn       = slots[pick];
         gen_state   = step_lcg(gen_state);
         slots[pick] = gen_state;
         last_value  = drawn;
         pending_draws.push_back(drawn);
      endfunction

      function void check_value(logic [VAL_W-1:0] actual);
         logic [VAL_W-1:0] wanted;
         if (pending_draws.size() == 0) begin
            $error("random_value: expected none, actual %0d", actual);
            errors++;
         end else begin
            wanted = pending_draws.pop_front();
            if (actual !== wanted) begin
               $error("random_value: expected %0d, actual %0d", wanted, actual);
               errors++;
            end
         end
      endfunction

      function int pending_count();
         return pending_draws.size();
      endfunction
   endclass

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic                     req_opcode       = OP_DRAW;
   logic signed [SEED_W-1:0] req_seed         = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic [VAL_W-1:0]         rsp_random_value;

   draw_scoreboard sb = new();
   bit             calm = 1'b0;
   int unsigned    idle_cycles = 0;

   shuffled_lcg_random_generator_unit #(
      .TABLE_DEPTH(DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_seed(req_seed),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_random_value(rsp_random_value)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Beat monitor: inputs are noted before results are checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_opcode, req_seed);
         if (rsp_valid && !rsp_stall) sb.check_value(rsp_random_value);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("shuffled_lcg_random_generator_unit: mismatch");
            $finish;
         end
      end
   end

   // Receiver back-pressure in random bursts.
   initial begin
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_beat(logic opcode, logic signed [SEED_W-1:0] seed);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= opcode;
      req_seed   <= seed;
      do @(posedge clock); while (req_stall);
   endtask

   // one edge first so the monitor has noted the last accepted beat
   task automatic wait_all_drawn();
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   initial begin
      logic                     op;
      logic signed [SEED_W-1:0] seed;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // draw before seeding must seed from the seed field
      send_beat(OP_DRAW, 21'sd714024);
      send_beat(OP_DRAW, -21'sd1);
      send_beat(OP_DRAW, 21'sd0);
      send_beat(OP_RESEED, -21'sd714024);
      send_beat(OP_DRAW, 21'sd5);
      send_beat(OP_RESEED, 21'sd0);
      send_beat(OP_DRAW, -21'sd714024);
      // seeds that map to a zero start, directly and through the wrap
      send_beat(OP_RESEED, 21'sd150889);
      send_beat(OP_DRAW, 21'sd0);
      send_beat(OP_RESEED, 21'sd864914);
      send_beat(OP_DRAW, 21'sd0);
      // patterns outside the nominal seed range, then seeds inside it
      send_beat(OP_RESEED, -21'sd1048576);
      send_beat(OP_DRAW, 21'sd1048575);
      send_beat(OP_RESEED, 21'sd1048575);
      send_beat(OP_DRAW, -21'sd1048576);
      send_beat(OP_RESEED, -21'sd1);
      send_beat(OP_RESEED, 21'sd714024);
      send_beat(OP_DRAW, 21'sd1);
      send_beat(OP_DRAW, 21'sd2);
      send_beat(OP_RESEED, 21'sd1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            req_valid <= 1'b0;
            wait_all_drawn();
         end
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         op = ($urandom_range(0, 15) == 0) ? OP_RESEED : OP_DRAW;
         if ($urandom_range(0, 1) == 0)
            seed = SEED_W'($signed($urandom_range(0, 1428048)) - 714024);
         else
            seed = SEED_W'($urandom);
         send_beat(op, seed);
      end
      req_valid <= 1'b0;

      wait_all_drawn();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_count() == 0)
         $display("shuffled_lcg_random_generator_unit: match");
      else
         $display("shuffled_lcg_random_generator_unit: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/slcg_pkg.sv
rtl/core/slcg_divmod.sv
rtl/core/slcg_queue.sv
rtl/core/slcg_front.sv
rtl/core/slcg_back.sv
rtl/core/shuffled_lcg_random_generator_unit.sv
tb/tb_shuffled_lcg_random_generator_unit.sv
